[src/gpf_pkg.sv]
package gpf_pkg;

	localparam int ELEV_IN_W = 16;
	localparam int AREA_W    = 13;
	localparam int YEAR_W    = 16;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_YEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

	localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

	// Size registers come out of reset at 64, clamped to MAX_ROWS and MAX_COLS.
	localparam int SIZE_RESET = 64;

	// Neighbor order: east, south, west, north.
	typedef enum logic [1:0] {
		DIR_E = 2'd0,
		DIR_S = 2'd1,
		DIR_W = 2'd2,
		DIR_N = 2'd3
	} dir_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_CLEAR,
		CMD_SEED_INIT,
		CMD_SEED_CELL,
		CMD_SEED_TAKE,
		CMD_SEED_ADV,
		CMD_PUSH_INIT,
		CMD_UP,
		CMD_UP_STEP,
		CMD_YEAR,
		CMD_TOP_READ,
		CMD_POP,
		CMD_LAST_READ,
		CMD_LAST_TAKE,
		CMD_SIFT_READ,
		CMD_SIFT_L,
		CMD_SIFT_R,
		CMD_SIFT_STEP,
		CMD_NB_READ,
		CMD_NB_TAKE,
		CMD_NB_ADV,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic seeded;
		logic seed_border;
		logic seed_last;
		logic heap_full;
		logic heap_empty;
		logic hole_zero;
		logic up_less;
		logic top_sinks;
		logic has_l;
		logic has_r;
		logic nk_first;
		logic nb_inside;
		logic nb_fresh;
		logic dir_last;
		logic out_free;
	} status_t;

endpackage

[src/gpf_in_if.sv]
interface gpf_in_if import gpf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [ELEV_IN_W-1:0] elevation;

	modport source(output valid, op, elevation, input ready);
	modport sink(input valid, op, elevation, output ready);
endinterface

[src/gpf_out_if.sv]
interface gpf_out_if import gpf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] remaining_area;
	logic [YEAR_W-1:0] year_number;

	modport source(output valid, remaining_area, year_number, input ready);
	modport sink(input valid, remaining_area, year_number, output ready);
endinterface

[src/gpf_ram.sv]
module gpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/gpf_ctrl.sv]
module gpf_ctrl import gpf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_op,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [21:0] {
		S_CLEAR     = 22'd1 << 0,
		S_IDLE      = 22'd1 << 1,
		S_SEED_INIT = 22'd1 << 2,
		S_SEED_CELL = 22'd1 << 3,
		S_SEED_WAIT = 22'd1 << 4,
		S_SEED_ADV  = 22'd1 << 5,
		S_PUSH      = 22'd1 << 6,
		S_UP        = 22'd1 << 7,
		S_UP_CMP    = 22'd1 << 8,
		S_YEAR      = 22'd1 << 9,
		S_TOP       = 22'd1 << 10,
		S_TOP_CHK   = 22'd1 << 11,
		S_LAST      = 22'd1 << 12,
		S_LAST_WAIT = 22'd1 << 13,
		S_SIFT      = 22'd1 << 14,
		S_SIFT_L    = 22'd1 << 15,
		S_SIFT_R    = 22'd1 << 16,
		S_SIFT_DEC  = 22'd1 << 17,
		S_NB_CHK    = 22'd1 << 18,
		S_NB_WAIT   = 22'd1 << 19,
		S_NB_ADV    = 22'd1 << 20,
		S_OUT       = 22'd1 << 21
	} state_t;

	state_t state_q, state_d;
	logic   from_seed_q, from_seed_d;
	state_t push_ret;
	state_t nb_next;

	assign push_ret = from_seed_q ? S_SEED_ADV : S_NB_ADV;
	assign nb_next  = st.dir_last ? S_TOP : S_NB_CHK;

	always_comb begin
		state_d     = state_q;
		from_seed_d = from_seed_q;
		cmd         = CMD_NONE;
		in_ready    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd = CMD_CLEAR;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_LOAD) begin
						cmd = CMD_LOAD;
					end else begin
						state_d = st.seeded ? S_YEAR : S_SEED_INIT;
					end
				end
			end
			S_SEED_INIT: begin
				cmd     = CMD_SEED_INIT;
				state_d = S_SEED_CELL;
			end
			S_SEED_CELL: begin
				if (st.seed_border) begin
					cmd     = CMD_SEED_CELL;
					state_d = S_SEED_WAIT;
				end else begin
					cmd     = CMD_SEED_ADV;
					state_d = st.seed_last ? S_YEAR : S_SEED_CELL;
				end
			end
			S_SEED_WAIT: begin
				cmd         = CMD_SEED_TAKE;
				from_seed_d = 1'b1;
				state_d     = S_PUSH;
			end
			S_SEED_ADV: begin
				cmd     = CMD_SEED_ADV;
				state_d = st.seed_last ? S_YEAR : S_SEED_CELL;
			end
			S_PUSH: begin
				cmd     = CMD_PUSH_INIT;
				state_d = st.heap_full ? push_ret : S_UP;
			end
			S_UP: begin
				cmd     = CMD_UP;
				state_d = st.hole_zero ? push_ret : S_UP_CMP;
			end
			S_UP_CMP: begin
				cmd     = CMD_UP_STEP;
				state_d = st.up_less ? S_UP : push_ret;
			end
			S_YEAR: begin
				cmd     = CMD_YEAR;
				state_d = S_TOP;
			end
			S_TOP: begin
				if (st.heap_empty) begin
					state_d = S_OUT;
				end else begin
					cmd     = CMD_TOP_READ;
					state_d = S_TOP_CHK;
				end
			end
			S_TOP_CHK: begin
				if (st.top_sinks) begin
					cmd     = CMD_POP;
					state_d = S_LAST;
				end else begin
					state_d = S_OUT;
				end
			end
			S_LAST: begin
				if (st.heap_empty) begin
					state_d = S_NB_CHK;
				end else begin
					cmd     = CMD_LAST_READ;
					state_d = S_LAST_WAIT;
				end
			end
			S_LAST_WAIT: begin
				cmd     = CMD_LAST_TAKE;
				state_d = S_SIFT;
			end
			S_SIFT: begin
				cmd     = CMD_SIFT_READ;
				state_d = st.has_l ? S_SIFT_L : S_NB_CHK;
			end
			S_SIFT_L: begin
				cmd     = CMD_SIFT_L;
				state_d = st.has_r ? S_SIFT_R : S_SIFT_DEC;
			end
			S_SIFT_R: begin
				cmd     = CMD_SIFT_R;
				state_d = S_SIFT_DEC;
			end
			S_SIFT_DEC: begin
				cmd     = CMD_SIFT_STEP;
				state_d = st.nk_first ? S_NB_CHK : S_SIFT;
			end
			S_NB_CHK: begin
				if (st.nb_inside) begin
					cmd     = CMD_NB_READ;
					state_d = S_NB_WAIT;
				end else begin
					cmd     = CMD_NB_ADV;
					state_d = nb_next;
				end
			end
			S_NB_WAIT: begin
				if (st.nb_fresh) begin
					cmd         = CMD_NB_TAKE;
					from_seed_d = 1'b0;
					state_d     = S_PUSH;
				end else begin
					cmd     = CMD_NB_ADV;
					state_d = nb_next;
				end
			end
			S_NB_ADV: begin
				cmd     = CMD_NB_ADV;
				state_d = nb_next;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd     = CMD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			from_seed_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			from_seed_q <= from_seed_d;
		end
	end

endmodule

[src/gpf_dp.sv]
module gpf_dp import gpf_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int ELEV_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              st,
	input  logic [ELEV_IN_W-1:0] elevation,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [AREA_W-1:0]    remaining_area,
	output logic [YEAR_W-1:0]    year_number
);

	localparam int CAP  = MAX_ROWS * MAX_COLS;
	localparam int AW   = $clog2(CAP);
	localparam int CNTW = $clog2(CAP + 1);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CW   = $clog2(MAX_COLS);
	localparam int RSW  = $clog2(MAX_ROWS + 1);
	localparam int CSW  = $clog2(MAX_COLS + 1);
	localparam int EW   = ELEV_BITS;
	localparam int CMPW = (EW > YEAR_W) ? EW : YEAR_W;
	localparam int ROWS_RST = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;
	localparam int COLS_RST = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;
	localparam logic [CNTW-1:0] CAP_N = CNTW'(CAP);

	// Heap order is elevation first, then row-major cell index; row and column
	// ride along so that neighbors need no division.
	typedef struct packed {
		logic [EW-1:0] elev;
		logic [AW-1:0] pos;
		logic [RW-1:0] r;
		logic [CW-1:0] c;
	} entry_t;

	localparam int ENW = $bits(entry_t);

	function automatic logic key_less(entry_t a, entry_t b);
		return {a.elev, a.pos} < {b.elev, b.pos};
	endfunction

	logic [RSW-1:0]    grid_rows_q, frozen_rows_q;
	logic [CSW-1:0]    grid_cols_q, frozen_cols_q;
	logic              seeded_q;
	logic [YEAR_W-1:0] year_q;
	logic [CNTW-1:0]   area_q, count_q, load_pos_q;
	logic [AW-1:0]     clr_q;
	logic [RW-1:0]     seed_r_q;
	logic [CW-1:0]     seed_c_q;
	logic [AW-1:0]     seed_cell_q;
	logic [AW-1:0]     hole_q, cand_idx_q;
	entry_t            nk_q, cand_q, pop_q;
	dir_t              dir_q;
	logic              out_valid_q;
	logic [AREA_W-1:0] out_area_q;
	logic [YEAR_W-1:0] out_year_q;

	logic           heap_we, heap_re;
	logic [AW-1:0]  heap_waddr, heap_raddr;
	logic [ENW-1:0] heap_wdata, heap_rdata;
	entry_t         heap_rd;
	logic           elev_we, elev_re;
	logic [AW-1:0]  elev_waddr, elev_raddr;
	logic [EW-1:0]  elev_rdata;
	logic           vis_we, vis_re, vis_wdata, vis_rdata;
	logic [AW-1:0]  vis_waddr, vis_raddr;

	logic [AW-1:0] parent;
	logic [AW:0]   l_idx, r_idx, count_x;
	logic          has_l, has_r, up_less, nk_first, top_sinks;
	logic          seed_border, seed_last, seed_r_end, seed_c_end;
	logic          nb_inside;
	logic [AW-1:0] nb_cell;
	logic [RW-1:0] nb_r;
	logic [CW-1:0] nb_c;
	logic          out_free;

	assign heap_rd = entry_t'(heap_rdata);

	assign parent    = AW'((hole_q - 1'b1) >> 1);
	assign l_idx     = {hole_q, 1'b1};
	assign r_idx     = l_idx + 1'b1;
	assign count_x   = (AW + 1)'(count_q);
	assign has_l     = l_idx < count_x;
	assign has_r     = r_idx < count_x;
	assign up_less   = key_less(nk_q, heap_rd);
	assign nk_first  = key_less(nk_q, cand_q);
	assign top_sinks = CMPW'(heap_rd.elev) <= CMPW'(year_q);

	assign seed_r_end  = RSW'(seed_r_q) == frozen_rows_q - 1'b1;
	assign seed_c_end  = CSW'(seed_c_q) == frozen_cols_q - 1'b1;
	assign seed_border = (seed_r_q == '0) || seed_r_end || (seed_c_q == '0) || seed_c_end;
	assign seed_last   = seed_r_end && seed_c_end;

	always_comb begin
		nb_inside = 1'b0;
		nb_cell   = pop_q.pos;
		nb_r      = pop_q.r;
		nb_c      = pop_q.c;
		unique case (dir_q)
			DIR_E: begin
				nb_inside = (CSW + 1)'(pop_q.c) + 1'b1 < (CSW + 1)'(frozen_cols_q);
				nb_cell   = pop_q.pos + 1'b1;
				nb_c      = pop_q.c + 1'b1;
			end
			DIR_S: begin
				nb_inside = (RSW + 1)'(pop_q.r) + 1'b1 < (RSW + 1)'(frozen_rows_q);
				nb_cell   = pop_q.pos + AW'(frozen_cols_q);
				nb_r      = pop_q.r + 1'b1;
			end
			DIR_W: begin
				nb_inside = pop_q.c != '0;
				nb_cell   = pop_q.pos - 1'b1;
				nb_c      = pop_q.c - 1'b1;
			end
			DIR_N: begin
				nb_inside = pop_q.r != '0;
				nb_cell   = pop_q.pos - AW'(frozen_cols_q);
				nb_r      = pop_q.r - 1'b1;
			end
			default: begin
				nb_inside = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		st.clr_last    = clr_q == AW'(CAP - 1);
		st.seeded      = seeded_q;
		st.seed_border = seed_border;
		st.seed_last   = seed_last;
		st.heap_full   = count_q == CAP_N;
		st.heap_empty  = count_q == '0;
		st.hole_zero   = hole_q == '0;
		st.up_less     = up_less;
		st.top_sinks   = top_sinks;
		st.has_l       = has_l;
		st.has_r       = has_r;
		st.nk_first    = nk_first;
		st.nb_inside   = nb_inside;
		st.nb_fresh    = !vis_rdata;
		st.dir_last    = dir_q == DIR_N;
		st.out_free    = out_free;
	end

	// Memory port steering.
	always_comb begin
		heap_we    = 1'b0;
		heap_re    = 1'b0;
		heap_waddr = hole_q;
		heap_raddr = '0;
		heap_wdata = nk_q;
		elev_we    = 1'b0;
		elev_re    = 1'b0;
		elev_waddr = load_pos_q[AW-1:0];
		elev_raddr = nb_cell;
		vis_we     = 1'b0;
		vis_re     = 1'b0;
		vis_waddr  = nb_cell;
		vis_raddr  = nb_cell;
		vis_wdata  = 1'b1;
		unique case (cmd)
			CMD_LOAD: begin
				elev_we = load_pos_q < CAP_N;
			end
			CMD_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = 1'b0;
			end
			CMD_SEED_CELL: begin
				elev_re    = 1'b1;
				elev_raddr = seed_cell_q;
				vis_we     = 1'b1;
				vis_waddr  = seed_cell_q;
			end
			CMD_UP: begin
				if (hole_q == '0) begin
					heap_we = 1'b1;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = parent;
				end
			end
			CMD_UP_STEP: begin
				heap_we    = 1'b1;
				heap_wdata = up_less ? heap_rd : nk_q;
			end
			CMD_TOP_READ: begin
				heap_re = 1'b1;
			end
			CMD_LAST_READ: begin
				heap_re    = 1'b1;
				heap_raddr = count_q[AW-1:0];
			end
			CMD_SIFT_READ: begin
				if (has_l) begin
					heap_re    = 1'b1;
					heap_raddr = l_idx[AW-1:0];
				end else begin
					heap_we = 1'b1;
				end
			end
			CMD_SIFT_L: begin
				heap_re    = has_r;
				heap_raddr = r_idx[AW-1:0];
			end
			CMD_SIFT_STEP: begin
				heap_we    = 1'b1;
				heap_wdata = nk_first ? nk_q : cand_q;
			end
			CMD_NB_READ: begin
				elev_re = 1'b1;
				vis_re  = 1'b1;
			end
			CMD_NB_TAKE: begin
				vis_we = 1'b1;
			end
			default: begin
				heap_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= RSW'(ROWS_RST);
			grid_cols_q   <= CSW'(COLS_RST);
			frozen_rows_q <= RSW'(ROWS_RST);
			frozen_cols_q <= CSW'(COLS_RST);
			seeded_q      <= 1'b0;
			year_q        <= '0;
			area_q        <= '0;
			count_q       <= '0;
			load_pos_q    <= '0;
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_ROWS: begin
						if (cfg_data == '0) begin
							grid_rows_q <= RSW'(1);
						end else if (int'(cfg_data) > MAX_ROWS) begin
							grid_rows_q <= RSW'(MAX_ROWS);
						end else begin
							grid_rows_q <= RSW'(cfg_data);
						end
					end
					REG_GRID_COLS: begin
						if (cfg_data == '0) begin
							grid_cols_q <= CSW'(1);
						end else if (int'(cfg_data) > MAX_COLS) begin
							grid_cols_q <= CSW'(MAX_COLS);
						end else begin
							grid_cols_q <= CSW'(cfg_data);
						end
					end
					default: begin
						grid_rows_q <= grid_rows_q;
					end
				endcase
			end
			// A new result may replace one that leaves in the same cycle.
			if (cmd == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd)
				CMD_LOAD: begin
					if (load_pos_q < CAP_N) begin
						load_pos_q <= load_pos_q + 1'b1;
					end
				end
				CMD_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				CMD_SEED_INIT: begin
					frozen_rows_q <= grid_rows_q;
					frozen_cols_q <= grid_cols_q;
					area_q        <= CNTW'(grid_rows_q * grid_cols_q);
					seeded_q      <= 1'b1;
				end
				CMD_PUSH_INIT: begin
					if (count_q != CAP_N) begin
						count_q <= count_q + 1'b1;
					end
				end
				CMD_YEAR: begin
					if (year_q != YEAR_MAX) begin
						year_q <= year_q + 1'b1;
					end
				end
				CMD_POP: begin
					count_q <= count_q - 1'b1;
					if (area_q != '0) begin
						area_q <= area_q - 1'b1;
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// Working registers; every sequence loads them before use.
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_SEED_INIT: begin
				seed_r_q    <= '0;
				seed_c_q    <= '0;
				seed_cell_q <= '0;
			end
			CMD_SEED_TAKE: begin
				nk_q <= '{elev: elev_rdata, pos: seed_cell_q, r: seed_r_q, c: seed_c_q};
			end
			CMD_SEED_ADV: begin
				seed_cell_q <= seed_cell_q + 1'b1;
				if (seed_c_end) begin
					seed_c_q <= '0;
					seed_r_q <= seed_r_q + 1'b1;
				end else begin
					seed_c_q <= seed_c_q + 1'b1;
				end
			end
			CMD_PUSH_INIT: begin
				hole_q <= count_q[AW-1:0];
			end
			CMD_UP_STEP: begin
				if (up_less) begin
					hole_q <= parent;
				end
			end
			CMD_POP: begin
				pop_q  <= heap_rd;
				hole_q <= '0;
				dir_q  <= DIR_E;
			end
			CMD_LAST_TAKE: begin
				nk_q <= heap_rd;
			end
			CMD_SIFT_L: begin
				cand_q     <= heap_rd;
				cand_idx_q <= l_idx[AW-1:0];
			end
			CMD_SIFT_R: begin
				if (key_less(heap_rd, cand_q)) begin
					cand_q     <= heap_rd;
					cand_idx_q <= r_idx[AW-1:0];
				end
			end
			CMD_SIFT_STEP: begin
				if (!nk_first) begin
					hole_q <= cand_idx_q;
				end
			end
			CMD_NB_TAKE: begin
				nk_q <= '{elev: elev_rdata, pos: nb_cell, r: nb_r, c: nb_c};
			end
			CMD_NB_ADV: begin
				dir_q <= dir_t'(dir_q + 2'd1);
			end
			CMD_OUT: begin
				out_area_q <= AREA_W'(area_q);
				out_year_q <= year_q;
			end
			default: begin
				hole_q <= hole_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign remaining_area = out_area_q;
	assign year_number    = out_year_q;

	gpf_ram #(.WIDTH(ENW), .DEPTH(CAP)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.re    (heap_re),
		.raddr (heap_raddr),
		.rdata (heap_rdata)
	);

	gpf_ram #(.WIDTH(EW), .DEPTH(CAP)) u_elev_ram (
		.clk   (clk),
		.we    (elev_we),
		.waddr (elev_waddr),
		.wdata (EW'(elevation)),
		.re    (elev_re),
		.raddr (elev_raddr),
		.rdata (elev_rdata)
	);

	gpf_ram #(.WIDTH(1), .DEPTH(CAP)) u_visit_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (vis_re),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

endmodule

[src/grid_priority_flood_sinking_core.sv]
// Priority-flood sinking of an elevation grid. After reset the block clears
// all MAX_ROWS*MAX_COLS entries of its visited map and accepts no item until
// that is done. A load item is written straight into the elevation store. A
// year tick bumps the year and then handles every cell it sinks: it reads the
// heap top, pops it with a sift-down that reads the left and right children
// and moves the hole down a heap level at a time, then makes up to four
// neighbor checks, each new neighbor pushed with a sift-up that reads and
// compares the parent at every level. All heap traffic goes through the
// single read port of the heap RAM. The first tick also scans the whole grid
// once, with a push for every border cell. Results wait in an output register,
// and loads are taken while a result is still pending.
module grid_priority_flood_sinking_core import gpf_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int ELEV_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gpf_in_if.sink               item,
	gpf_out_if.source            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t    cmd;
	status_t st;

	gpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.in_ready (item.ready),
		.st       (st),
		.cmd      (cmd)
	);

	gpf_dp #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.ELEV_BITS (ELEV_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.elevation      (item.elevation),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.remaining_area (result.remaining_area),
		.year_number    (result.year_number)
	);

endmodule

[src/gpf_check.sv]
module gpf_check import gpf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [AREA_W-1:0] remaining_area,
	input logic [YEAR_W-1:0] year_number
);

	logic              seen_q;
	logic [AREA_W-1:0] last_area_q;
	logic [YEAR_W-1:0] last_year_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_area_q <= '0;
			last_year_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_q      <= 1'b1;
			last_area_q <= remaining_area;
			last_year_q <= year_number;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(remaining_area) && $stable(year_number))
		else $error("result beat changed while stalled");

	a_year_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> year_number != '0)
		else $error("result reports year zero");

	a_area_falls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> remaining_area <= last_area_q)
		else $error("remaining area grew between results");

	a_year_rises: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> (year_number > last_year_q) || (last_year_q == YEAR_MAX))
		else $error("year did not advance between results");

endmodule

bind grid_priority_flood_sinking_core gpf_check u_gpf_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.remaining_area (result.remaining_area),
	.year_number    (result.year_number)
);

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gpf_pkg::*;

	localparam int GRID_CAP = 64 * 64;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic [YEAR_W-1:0] year;
	} sea_report_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	gpf_in_if  item_if ();
	gpf_out_if res_if ();

	grid_priority_flood_sinking_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if.sink),
		.result    (res_if.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow state of the flood.
	logic [15:0] cell_elev [GRID_CAP];
	bit          cell_seen [GRID_CAP];
	logic [15:0] heap_elev [GRID_CAP];
	int          heap_cell [GRID_CAP];
	int          heap_n = 0;
	int          land_left = 0;
	int          sea_year = 0;
	int          load_pos = 0;
	bit          border_done = 0;
	int          rows_reg = 64, cols_reg = 64, rows_fz = 64, cols_fz = 64;

	sea_report_t report_q[$];
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int          snk_hold = 0;
	int          errors = 0;
	int          ticks_sent = 0, loads_sent = 0, reports_seen = 0;

	function automatic bit key_lt(int a, int b);
		if (heap_elev[a] != heap_elev[b])
			return heap_elev[a] < heap_elev[b];
		return heap_cell[a] < heap_cell[b];
	endfunction

	function automatic void key_swap(int a, int b);
		logic [15:0] e;
		int c;
		e = heap_elev[a]; heap_elev[a] = heap_elev[b]; heap_elev[b] = e;
		c = heap_cell[a]; heap_cell[a] = heap_cell[b]; heap_cell[b] = c;
	endfunction

	function automatic void mark_cell(int cid);
		int i;
		if (cid >= GRID_CAP || cell_seen[cid])
			return;
		cell_seen[cid] = 1;
		if (heap_n >= GRID_CAP)
			return;
		i = heap_n++;
		heap_elev[i] = cell_elev[cid];
		heap_cell[i] = cid;
		while (i > 0 && key_lt(i, (i - 1) / 2)) begin
			key_swap(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
	endfunction

	function automatic void heap_drop_top();
		int i, l, r, m;
		i = 0;
		heap_n--;
		heap_elev[0] = heap_elev[heap_n];
		heap_cell[0] = heap_cell[heap_n];
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < heap_n && key_lt(l, m))
				m = l;
			if (r < heap_n && key_lt(r, m))
				m = r;
			if (m == i)
				break;
			key_swap(i, m);
			i = m;
		end
	endfunction

	function automatic int clamp_size(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > 64)
			return 64;
		return v;
	endfunction

	// Advances the shadow flood by one year and returns the report it gives.
	function automatic sea_report_t flood_year_tick();
		sea_report_t rep;
		int cid, r, c;
		if (!border_done) begin
			rows_fz = rows_reg;
			cols_fz = cols_reg;
			for (int y = 0; y < rows_fz; y++)
				for (int x = 0; x < cols_fz; x++)
					if (y == 0 || y == rows_fz - 1 || x == 0 || x == cols_fz - 1)
						mark_cell(y * cols_fz + x);
			land_left = rows_fz * cols_fz;
			border_done = 1;
		end
		if (sea_year < 65535)
			sea_year++;
		while (heap_n > 0 && heap_elev[0] <= sea_year) begin
			cid = heap_cell[0];
			r = cid / cols_fz;
			c = cid % cols_fz;
			heap_drop_top();
			if (land_left > 0)
				land_left--;
			if (c + 1 < cols_fz) mark_cell(r * cols_fz + c + 1);
			if (r + 1 < rows_fz) mark_cell((r + 1) * cols_fz + c);
			if (c > 0)           mark_cell(r * cols_fz + c - 1);
			if (r > 0)           mark_cell((r - 1) * cols_fz + c);
		end
		rep.area = land_left[AREA_W-1:0];
		rep.year = sea_year[YEAR_W-1:0];
		return rep;
	endfunction

	initial begin
		item_if.valid = 1'b0;
		item_if.op = OP_LOAD;
		item_if.elevation = '0;
		res_if.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (snk_hold > 0) begin
			snk_hold <= snk_hold - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		sea_report_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			reports_seen++;
			if (report_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected report area=%0d year=%0d", $realtime,
					res_if.remaining_area, res_if.year_number);
			end else begin
				want = report_q.pop_front();
				if (res_if.remaining_area !== want.area) begin
					errors++;
					$display("%0t: remaining_area expected %0d actual %0d", $realtime,
						want.area, res_if.remaining_area);
				end
				if (res_if.year_number !== want.year) begin
					errors++;
					$display("%0t: year_number expected %0d actual %0d", $realtime,
						want.year, res_if.year_number);
				end
			end
		end
	end

	// Offers one beat, with a random gap first, and updates the shadow on acceptance.
	task automatic send_beat(input logic op, input logic [15:0] elev);
		if ($urandom_range(99) < src_idle_pct) begin
			item_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		item_if.valid <= 1'b1;
		item_if.op <= op;
		item_if.elevation <= elev;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		if (op == OP_YEAR) begin
			report_q.push_back(flood_year_tick());
			ticks_sent++;
		end else begin
			if (load_pos < GRID_CAP)
				cell_elev[load_pos++] = elev;
			loads_sent++;
		end
	endtask

	task automatic stop_and_drain();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_GRID_ROWS)
			rows_reg = clamp_size(v);
		else
			cols_reg = clamp_size(v);
	endtask

	task automatic test_size_registers();
		write_reg(REG_GRID_ROWS, 7'd0);
		write_reg(REG_GRID_COLS, 7'd1);
		write_reg(REG_GRID_ROWS, 7'd33);
		write_reg(REG_GRID_COLS, 7'd64);
		// Above the maximum: both saturate to the full 64 x 64 grid.
		write_reg(REG_GRID_ROWS, 7'd127);
		write_reg(REG_GRID_COLS, 7'd127);
		// The flood itself runs on a smaller grid.
		write_reg(REG_GRID_ROWS, 7'd20);
		write_reg(REG_GRID_COLS, 7'd24);
	endtask

	task automatic test_grid_load();
		logic [15:0] e;
		src_idle_pct = 18;
		snk_idle_pct = 74;
		for (int i = 0; i < rows_reg * cols_reg; i++) begin
			case (i)
				0: e = 16'h0000;
				1: e = 16'hFFFF;
				2: e = 16'h5555;
				3: e = 16'hAAAA;
				default: e = ($urandom_range(49) == 0) ? 16'($urandom)
					: 16'($urandom_range(2500));
			endcase
			send_beat(OP_LOAD, e);
		end
	endtask

	task automatic test_first_year();
		send_beat(OP_YEAR, '0);
		// These loads land in the store past the grid in use.
		for (int i = 0; i < 4; i++)
			send_beat(OP_LOAD, 16'($urandom));
		stop_and_drain();
		// Size writes after the grid is frozen must change nothing.
		write_reg(REG_GRID_ROWS, 7'd5);
		write_reg(REG_GRID_COLS, 7'd0);
	endtask

	task automatic test_random_years();
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 74 : 0;
			snk_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 18 : 0;
			for (int i = 0; i < 500; i++)
				send_beat(($urandom_range(9) == 0) ? OP_LOAD : OP_YEAR, 16'($urandom));
		end
		src_idle_pct = 0;
		snk_idle_pct = 0;
	endtask

	task automatic test_backpressure();
		snk_hold = 300;
		for (int i = 0; i < 20; i++)
			send_beat(OP_YEAR, '0);
		stop_and_drain();
		for (int i = 0; i < 20; i++)
			send_beat(OP_YEAR, '0);
		stop_and_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_size_registers();
		test_grid_load();
		test_first_year();
		test_random_years();
		test_backpressure();
		$display("Flooded a %0dx%0d grid: %0d loads, %0d year ticks, %0d reports checked.",
			rows_fz, cols_fz, loads_sent, ticks_sent, reports_seen);
		$display("Covered size clamping, a frozen grid size, output stalls and drained pauses.");
		if (errors == 0 && report_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#50ms;
		$display("Timeout with %0d reports outstanding.", report_q.size());
		$display("TEST FAILED");
		$finish;
	end
endmodule
